FILE: design/nsr_pkg.sv
// ----------------------------------------------------------------------------
// nsr_pkg
// Shared widths, constants and codes of the Newton square root core.
// ----------------------------------------------------------------------------
package nsr_pkg;

  // Field widths.
  localparam int VAL_W     = 32;            // radicand
  localparam int TOL_W     = 24;            // relative tolerance, Q0.24
  localparam int ROOT_W    = 24;            // saturated root
  localparam int STAT_W    = 2;
  localparam int STEP_W    = 6;

  // Number format and iteration cap.
  localparam int FRAC_BITS = 16;
  localparam int MAX_STEPS = 32;

  // Internal datapath widths.
  localparam int GUESS_W   = 32;                  // guess, 0 .. 2^32-1 (0 only for a zero input)
  localparam int VF_W      = VAL_W + FRAC_BITS;   // value in Q.2F
  localparam int SQ_W      = 2 * GUESS_W;         // guess squared
  localparam int HALF_W    = GUESS_W / 2;         // multiplier B operand
  localparam int MUL_A_W   = GUESS_W;
  localparam int MUL_P_W   = MUL_A_W + HALF_W;
  localparam int TV_W      = VAL_W + TOL_W;       // tolerance times value
  localparam int TP_W      = TV_W + FRAC_BITS;    // tolerance times value in Q.2F
  localparam int TH_W      = TP_W - TOL_W;        // integer part of the bound

  localparam logic [TOL_W-1:0]  TOL_RESET = TOL_W'(1678);
  localparam logic [ROOT_W-1:0] ROOT_MAX  = '1;

  typedef enum logic [STAT_W-1:0] {
    ST_CONV = 2'd0,
    ST_ZERO = 2'd1,
    ST_CAP  = 2'd2
  } status_e;

  typedef enum logic [10:0] {
    S_IDLE = 11'b000_0000_0001,
    S_TOLA = 11'b000_0000_0010,
    S_TOLB = 11'b000_0000_0100,
    S_TOLC = 11'b000_0000_1000,
    S_SQA  = 11'b000_0001_0000,
    S_SQB  = 11'b000_0010_0000,
    S_SQC  = 11'b000_0100_0000,
    S_DIFF = 11'b000_1000_0000,
    S_CHK  = 11'b001_0000_0000,
    S_DIV  = 11'b010_0000_0000,
    S_FIN  = 11'b100_0000_0000
  } state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

FILE: design/newton_square_root_core.sv
// ----------------------------------------------------------------------------
// newton_square_root_core
// Square root of an unsigned Q16.16 value by Newton iteration, built on a
// shared multiplier and a bit-serial divider under a small sequencer.
// ----------------------------------------------------------------------------
//  Channel  Handshake                 Payload
//  in       in_valid_i / in_ready_o   value_in_i
//  out      out_valid_o / out_ready_i root_out_o, status_o, steps_used_o
//  cfg      cfg_valid_i / cfg_ready_o cfg_data_i (relative tolerance, Q0.24)
//
// A zero input skips the Newton steps and goes straight to the finish state.
// Any other input takes up to 32 Newton steps, and the bit-serial divider
// sets the cost of each step.
// One item is worked on at a time; in_ready_o is high only when idle.
// A finished result waits in the output register while the next item enters.
// Reset sets the tolerance to 1678 and empties the output register.
// ----------------------------------------------------------------------------
module newton_square_root_core import nsr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [VAL_W-1:0]  value_in_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [ROOT_W-1:0] root_out_o,
  output logic [STAT_W-1:0] status_o,
  output logic [STEP_W-1:0] steps_used_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [TOL_W-1:0]  cfg_data_i
);

  state_e              state_q, state_d;
  logic                out_valid_q, out_valid_d;
  logic [TOL_W-1:0]    tol_q;

  logic [VAL_W-1:0]    v_q, v_d;
  logic [GUESS_W-1:0]  g_q, g_d;
  logic [STEP_W-1:0]   steps_q, steps_d;
  status_e             stat_q, stat_d;
  logic [SQ_W-1:0]     acc_q, acc_d;
  logic [SQ_W-1:0]     diff_q, diff_d;
  logic [TH_W-1:0]     th_q, th_d;
  logic                remnz_q, remnz_d;
  logic [ROOT_W-1:0]   root_q, root_d;
  status_e             ostat_q, ostat_d;
  logic [STEP_W-1:0]   osteps_q, osteps_d;

  logic [MUL_A_W-1:0]  mul_a;
  logic [HALF_W-1:0]   mul_b;
  logic [MUL_P_W-1:0]  mul_p;
  logic [SQ_W-1:0]     acc_sum;
  logic [TP_W-1:0]     tol_prod;
  logic [SQ_W-1:0]     vf_ext;
  logic                close;
  logic                div_start;
  logic [VF_W-1:0]     quot;
  div_stat_t           div_stat;
  logic [VF_W:0]       nsum;
  logic [VF_W-1:0]     nxt;
  logic [GUESS_W-1:0]  g_init;

  nsr_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  nsr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({v_q, {FRAC_BITS{1'b0}}}),
    .divisor_i  (g_q),
    .quot_o     (quot),
    .stat_o     (div_stat)
  );

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);

  // Operand selection for the shared multiplier: two half products each for
  // tolerance times value and for the square of the guess.
  always_comb begin
    mul_a = g_q;
    mul_b = g_q[HALF_W-1:0];
    case (state_q)
      S_TOLA: begin
        mul_a = MUL_A_W'(tol_q);
        mul_b = v_q[HALF_W-1:0];
      end
      S_TOLB: begin
        mul_a = MUL_A_W'(tol_q);
        mul_b = v_q[VAL_W-1:HALF_W];
      end
      S_SQB: begin
        mul_b = g_q[GUESS_W-1:HALF_W];
      end
      default: begin
        mul_a = g_q;
      end
    endcase
  end

  always_comb begin
    acc_sum  = acc_q + (SQ_W'(mul_p) << HALF_W);
    tol_prod = {acc_sum[TV_W-1:0], {FRAC_BITS{1'b0}}};
    vf_ext   = SQ_W'({v_q, {FRAC_BITS{1'b0}}});
    // |g*g - vf| * 2^24 < tol * vf, using the integer and fraction parts of
    // the bound.
    close    = (diff_q < SQ_W'(th_q)) || ((diff_q == SQ_W'(th_q)) && remnz_q);
    nsum     = {1'b0, VF_W'(g_q)} + {1'b0, quot};
    nxt      = nsum[VF_W:1];
    g_init   = {1'b0, value_in_i[VAL_W-1:1]};
    if (g_init == '0) begin
      g_init = GUESS_W'(1);
    end
    div_start = (state_q == S_CHK) && !close && (steps_q < STEP_W'(MAX_STEPS));
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    v_d         = v_q;
    g_d         = g_q;
    steps_d     = steps_q;
    stat_d      = stat_q;
    acc_d       = acc_q;
    diff_d      = diff_q;
    th_d        = th_q;
    remnz_d     = remnz_q;
    root_d      = root_q;
    ostat_d     = ostat_q;
    osteps_d    = osteps_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          v_d     = value_in_i;
          steps_d = '0;
          if (value_in_i == '0) begin
            g_d     = '0;
            stat_d  = ST_ZERO;
            state_d = S_FIN;
          end else begin
            g_d     = g_init;
            stat_d  = ST_CONV;
            state_d = S_TOLA;
          end
        end
      end
      S_TOLA: begin
        state_d = S_TOLB;
      end
      S_TOLB: begin
        acc_d   = SQ_W'(mul_p);
        state_d = S_TOLC;
      end
      S_TOLC: begin
        th_d    = tol_prod[TP_W-1 -: TH_W];
        remnz_d = |tol_prod[TOL_W-1:0];
        state_d = S_SQA;
      end
      S_SQA: begin
        state_d = S_SQB;
      end
      S_SQB: begin
        acc_d   = SQ_W'(mul_p);
        state_d = S_SQC;
      end
      S_SQC: begin
        acc_d   = acc_sum;
        state_d = S_DIFF;
      end
      S_DIFF: begin
        diff_d  = (acc_q >= vf_ext) ? (acc_q - vf_ext) : (vf_ext - acc_q);
        state_d = S_CHK;
      end
      S_CHK: begin
        if (close) begin
          stat_d  = ST_CONV;
          state_d = S_FIN;
        end else if (!div_start) begin
          stat_d  = ST_CAP;
          state_d = S_FIN;
        end else begin
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          // Next guess is clamped into the 32-bit guess range.
          if (|nxt[VF_W-1:GUESS_W]) begin
            g_d = '1;
          end else if (nxt == '0) begin
            g_d = GUESS_W'(1);
          end else begin
            g_d = nxt[GUESS_W-1:0];
          end
          steps_d = steps_q + STEP_W'(1);
          state_d = S_SQA;
        end
      end
      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          root_d      = (g_q > GUESS_W'(ROOT_MAX)) ? ROOT_MAX : g_q[ROOT_W-1:0];
          ostat_d     = stat_q;
          osteps_d    = steps_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      tol_q       <= TOL_RESET;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        tol_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    v_q      <= v_d;
    g_q      <= g_d;
    steps_q  <= steps_d;
    stat_q   <= stat_d;
    acc_q    <= acc_d;
    diff_q   <= diff_d;
    th_q     <= th_d;
    remnz_q  <= remnz_d;
    root_q   <= root_d;
    ostat_q  <= ostat_d;
    osteps_q <= osteps_d;
  end

  assign out_valid_o  = out_valid_q;
  assign root_out_o   = root_q;
  assign status_o     = ostat_q;
  assign steps_used_o = osteps_q;

endmodule

FILE: design/nsr_mul.sv
// ----------------------------------------------------------------------------
// nsr_mul
// Shared 32 x 16 unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module nsr_mul import nsr_pkg::*; (
  input  logic               clk_i,
  input  logic [MUL_A_W-1:0] a_i,
  input  logic [HALF_W-1:0]  b_i,
  output logic [MUL_P_W-1:0] p_o
);

  logic [MUL_P_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= MUL_P_W'(a_i) * MUL_P_W'(b_i);
  end

  assign p_o = p_q;

endmodule

FILE: design/nsr_div.sv
// ----------------------------------------------------------------------------
// nsr_div
// Restoring divider, one quotient bit per cycle (48-bit by 32-bit).
// ----------------------------------------------------------------------------
module nsr_div import nsr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [VF_W-1:0]    dividend_i,
  input  logic [GUESS_W-1:0] divisor_i,
  output logic [VF_W-1:0]    quot_o,
  output div_stat_t          stat_o
);

  localparam int CNT_W = $clog2(VF_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(VF_W - 1);

  logic               busy_q, done_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [GUESS_W-1:0] rem_q;
  logic [VF_W-1:0]    dvd_q;

  logic [GUESS_W:0]   rem_sh;
  logic [GUESS_W+1:0] trial;
  logic               qbit;
  logic [GUESS_W-1:0] rem_next;

  // The dividend shifts out at the top while quotient bits shift in below.
  always_comb begin
    rem_sh   = {rem_q, dvd_q[VF_W-1]};
    trial    = {1'b0, rem_sh} - {2'b00, divisor_i};
    qbit     = ~trial[GUESS_W+1];
    rem_next = qbit ? trial[GUESS_W-1:0] : rem_sh[GUESS_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dvd_q <= dividend_i;
    end else if (busy_q) begin
      rem_q <= rem_next;
      dvd_q <= {dvd_q[VF_W-2:0], qbit};
    end
  end

  assign quot_o      = dvd_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

FILE: design/nsr_chk.sv
// ----------------------------------------------------------------------------
// nsr_chk
// Port-level checks of the Newton square root core, bound to the top level.
// ----------------------------------------------------------------------------
module nsr_chk import nsr_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic [ROOT_W-1:0] root_out_o,
  input logic [STAT_W-1:0] status_o,
  input logic [STEP_W-1:0] steps_used_o
);

  // A stalled result keeps its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(root_out_o)
      && $stable(status_o) && $stable(steps_used_o))
    else $error("result changed while stalled");

  // Only one item is in flight: the input closes right after a transfer.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input ready right after a transfer");

  // A zero input reports a zero root and no steps.
  a_zero_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_ZERO) |-> (root_out_o == '0) && (steps_used_o == '0))
    else $error("zero input result is not empty");

  // Hitting the cap means every allowed step was used.
  a_cap_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_CAP) |-> (steps_used_o == STEP_W'(MAX_STEPS)))
    else $error("cap status with wrong step count");

  // A converged result never reports more steps than the cap.
  a_conv_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_CONV) |-> (steps_used_o <= STEP_W'(MAX_STEPS)))
    else $error("converged result beyond the step cap");

endmodule

bind newton_square_root_core nsr_chk u_nsr_chk (.*);
